>>> src/kbci_pkg.sv
package kbci_pkg;

    typedef enum logic [0:0] {
        ST_CLEAR,
        ST_RUN
    } state_t;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic signed [31:0] EMPTY_SCORE = 32'sh8000_0000;
    localparam logic [15:0]        PRED_NONE   = 16'hFFFF;

endpackage

>>> src/kbest_chart_cell_insert.sv
// On accept the cell row is read into a register; the update, write-back and result
//   register follow once the output is free. One item in flight: the row is read and
//   written back in the same single-port memory pair; the next item waits for write-back.
// Reset: synchronous, active low. Afterwards a clearing pass writes the empty marker to
//   every score row; s_ready stays low until it finishes.
module kbest_chart_cell_insert #(
    parameter int LIST_DEPTH    = 8,
    parameter int NUM_TAGS      = 32,
    parameter int NUM_POSITIONS = 128
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [6:0]         s_position,
    input  logic [4:0]         s_tag,
    input  logic [2:0]         s_rank,
    input  logic signed [31:0] s_score_in,
    input  logic [15:0]        s_feature_ref,
    input  logic [15:0]        s_pred_ref,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic               m_entry_valid,
    output logic signed [31:0] m_score_out,
    output logic [15:0]        m_feature_out,
    output logic [15:0]        m_pred_out
);

    // One memory row holds a whole cell list, entry 0 (best) in the low bits.
    localparam int NUM_CELLS = NUM_POSITIONS * NUM_TAGS;
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    kbci_pkg::state_t state_reg, state_next;
    logic [CELL_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clearing;
    logic              run;

    logic busy_reg, busy_next;       // row read issued, update still pending
    logic m_valid_reg, m_valid_next;

    logic accept;
    logic exec;                      // update/write-back cycle fires

    // Item fields held across the read cycle
    logic                    kind_reg;
    logic                    cell_ok_reg;
    logic [CELL_W-1:0]       cell_reg;
    logic [2:0]              rank_reg;
    logic signed [31:0]      score_reg;
    logic [15:0]             feat_reg;
    logic [15:0]             pred_reg;

    // Incoming cell address
    logic [31:0]       cell_full;
    logic [CELL_W-1:0] s_cell;
    logic              s_cell_ok;

    // Memories and read data
    logic [LIST_DEPTH-1:0][31:0] score_mem   [NUM_CELLS];
    logic [LIST_DEPTH-1:0][31:0] payload_mem [NUM_CELLS];
    logic [LIST_DEPTH-1:0][31:0] score_row_reg;
    logic [LIST_DEPTH-1:0][31:0] payload_row_reg;

    logic                        score_we;
    logic                        payload_we;
    logic [CELL_W-1:0]           waddr;
    logic [LIST_DEPTH-1:0][31:0] score_wdata;

    // Insert datapath
    logic [LIST_DEPTH-1:0]       lt;      // entry scores strictly below the new score
    logic [LIST_DEPTH-1:0]       seen;    // an earlier entry already scored below
    logic [LIST_DEPTH-1:0][31:0] ins_score_row;
    logic [LIST_DEPTH-1:0][31:0] ins_payload_row;
    logic                        worst_higher;
    logic                        ins_hit;

    // Read datapath
    logic signed [31:0] sel_score;
    logic [31:0]        sel_payload;
    logic               rd_valid;

    // Result item registers
    logic               m_accepted_reg;
    logic               m_entry_valid_reg;
    logic signed [31:0] m_score_out_reg;
    logic [15:0]        m_feature_out_reg;
    logic [15:0]        m_pred_out_reg;

    // ------------------------------------------------------------------
    // FSM: clearing pass, then normal operation
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            kbci_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CELL_W'(1);
                if (clr_cnt_reg == CELL_W'(NUM_CELLS - 1)) begin
                    state_next   = kbci_pkg::ST_RUN;
                    clr_cnt_next = '0;
                end
            end
            kbci_pkg::ST_RUN: begin
                state_next = kbci_pkg::ST_RUN;
            end
            default: begin
                state_next   = kbci_pkg::ST_CLEAR;
                clr_cnt_next = '0;
            end
        endcase
    end

    always_comb begin
        clearing = 1'b0;
        run      = 1'b0;
        case (state_reg)
            kbci_pkg::ST_CLEAR: clearing = 1'b1;
            kbci_pkg::ST_RUN:   run      = 1'b1;
            default:            clearing = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: one item in flight; the interlock on busy keeps the next
    // row read behind the previous write-back.
    // ------------------------------------------------------------------
    assign s_ready = run && !busy_reg;
    assign accept  = s_valid && s_ready;
    assign exec    = busy_reg && (!m_valid_reg || m_ready);

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (exec) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kbci_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell address: position-major, tag-minor
    // ------------------------------------------------------------------
    assign s_cell_ok = (32'(s_position) < NUM_POSITIONS) && (32'(s_tag) < NUM_TAGS);
    assign cell_full = s_cell_ok ? (32'(s_position) * NUM_TAGS + 32'(s_tag)) : 32'd0;
    assign s_cell    = cell_full[CELL_W-1:0];

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg    <= s_kind;
            cell_ok_reg <= s_cell_ok;
            cell_reg    <= s_cell;
            rank_reg    <= s_rank;
            score_reg   <= s_score_in;
            feat_reg    <= s_feature_ref;
            pred_reg    <= s_pred_ref;
        end
    end

    // ------------------------------------------------------------------
    // Row memories: read on accept, write back on exec, score rows also
    // swept during the clearing pass. Payload is never cleared.
    // ------------------------------------------------------------------
    assign score_we    = clearing || (exec && ins_hit);
    assign payload_we  = exec && ins_hit;
    assign waddr       = clearing ? clr_cnt_reg : cell_reg;
    assign score_wdata = clearing ? {LIST_DEPTH{kbci_pkg::EMPTY_SCORE}} : ins_score_row;

    always_ff @(posedge aclk) begin
        if (score_we) begin
            score_mem[waddr] <= score_wdata;
        end
        if (accept) begin
            score_row_reg <= score_mem[s_cell];
        end
    end

    always_ff @(posedge aclk) begin
        if (payload_we) begin
            payload_mem[cell_reg] <= ins_payload_row;
        end
        if (accept) begin
            payload_row_reg <= payload_mem[s_cell];
        end
    end

    // ------------------------------------------------------------------
    // Insert: new entry goes in front of the first strictly lower score,
    // everything below moves down one rank and the last entry drops out.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_ins
        assign lt[i] = $signed(score_row_reg[i]) < score_reg;
        if (i == 0) begin : g_first
            assign seen[i]            = 1'b0;
            assign ins_score_row[i]   = lt[i] ? score_reg : score_row_reg[i];
            assign ins_payload_row[i] = lt[i] ? {pred_reg, feat_reg} : payload_row_reg[i];
        end else begin : g_rest
            assign seen[i] = seen[i-1] | lt[i-1];
            always_comb begin
                if (seen[i]) begin
                    ins_score_row[i]   = score_row_reg[i-1];
                    ins_payload_row[i] = payload_row_reg[i-1];
                end else if (lt[i]) begin
                    ins_score_row[i]   = score_reg;
                    ins_payload_row[i] = {pred_reg, feat_reg};
                end else begin
                    ins_score_row[i]   = score_row_reg[i];
                    ins_payload_row[i] = payload_row_reg[i];
                end
            end
        end
    end

    assign worst_higher = $signed(score_row_reg[LIST_DEPTH-1]) > score_reg;
    assign ins_hit      = (kind_reg == kbci_pkg::KIND_INSERT) && cell_ok_reg
                          && !worst_higher && (|lt);

    // ------------------------------------------------------------------
    // Read: select one rank of the row
    // ------------------------------------------------------------------
    always_comb begin
        sel_score   = kbci_pkg::EMPTY_SCORE;
        sel_payload = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (32'(rank_reg) == i) begin
                sel_score   = score_row_reg[i];
                sel_payload = payload_row_reg[i];
            end
        end
    end

    assign rd_valid = cell_ok_reg && (32'(rank_reg) < LIST_DEPTH)
                      && (sel_score != kbci_pkg::EMPTY_SCORE);

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (exec) begin
            if (kind_reg == kbci_pkg::KIND_INSERT) begin
                m_accepted_reg    <= ins_hit;
                m_entry_valid_reg <= 1'b0;
                m_score_out_reg   <= '0;
                m_feature_out_reg <= '0;
                m_pred_out_reg    <= '0;
            end else if (rd_valid) begin
                m_accepted_reg    <= 1'b0;
                m_entry_valid_reg <= 1'b1;
                m_score_out_reg   <= sel_score;
                m_feature_out_reg <= sel_payload[15:0];
                m_pred_out_reg    <= sel_payload[31:16];
            end else begin
                m_accepted_reg    <= 1'b0;
                m_entry_valid_reg <= 1'b0;
                m_score_out_reg   <= kbci_pkg::EMPTY_SCORE;
                m_feature_out_reg <= '0;
                m_pred_out_reg    <= kbci_pkg::PRED_NONE;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = m_accepted_reg;
    assign m_entry_valid = m_entry_valid_reg;
    assign m_score_out   = m_score_out_reg;
    assign m_feature_out = m_feature_out_reg;
    assign m_pred_out    = m_pred_out_reg;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH    = 8;
    localparam int NUM_TAGS = 32;
    localparam int NUM_POS  = 128;
    localparam int RAND_ITEMS = 1900;
    localparam int HOT_CELLS  = 6;

    // one input item, as presented on the s_ channel
    typedef struct packed {
        logic               kind;
        logic [6:0]         position;
        logic [4:0]         tag;
        logic [2:0]         rank;
        logic signed [31:0] score;
        logic [15:0]        feature;
        logic [15:0]        pred;
    } req_t;

    // one result item, as seen on the m_ channel
    typedef struct packed {
        logic               accepted;
        logic               entry_valid;
        logic signed [31:0] score;
        logic [15:0]        feature;
        logic [15:0]        pred;
    } outcome_t;

    // directed row: item plus an optional hand-written expectation
    typedef struct packed {
        req_t     req;
        logic     typed;
        outcome_t want;
    } dir_row_t;

    localparam outcome_t EMPTY_READ  = '{1'b0, 1'b0, kbci_pkg::EMPTY_SCORE, 16'h0000,
                                         kbci_pkg::PRED_NONE};
    localparam outcome_t INS_PLACED  = '{1'b1, 1'b0, 32'sd0, 16'h0000, 16'h0000};
    localparam outcome_t INS_REFUSED = '{1'b0, 1'b0, 32'sd0, 16'h0000, 16'h0000};

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [6:0]         s_position;
    logic [4:0]         s_tag;
    logic [2:0]         s_rank;
    logic signed [31:0] s_score_in;
    logic [15:0]        s_feature_ref;
    logic [15:0]        s_pred_ref;
    logic               m_valid;
    logic               m_ready;
    logic               m_accepted;
    logic               m_entry_valid;
    logic signed [31:0] m_score_out;
    logic [15:0]        m_feature_out;
    logic [15:0]        m_pred_out;

    kbest_chart_cell_insert #(
        .LIST_DEPTH    (DEPTH),
        .NUM_TAGS      (NUM_TAGS),
        .NUM_POSITIONS (NUM_POS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_position    (s_position),
        .s_tag         (s_tag),
        .s_rank        (s_rank),
        .s_score_in    (s_score_in),
        .s_feature_ref (s_feature_ref),
        .s_pred_ref    (s_pred_ref),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_entry_valid (m_entry_valid),
        .m_score_out   (m_score_out),
        .m_feature_out (m_feature_out),
        .m_pred_out    (m_pred_out)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Shadow chart: per cell, DEPTH ranked entries, best first.
    // Payload is only looked at for entries holding a real score.
    logic signed [31:0] chart_score [NUM_POS*NUM_TAGS][DEPTH];
    logic [15:0]        chart_feat  [NUM_POS*NUM_TAGS][DEPTH];
    logic [15:0]        chart_pred  [NUM_POS*NUM_TAGS][DEPTH];

    outcome_t pending_outcomes[$];
    dir_row_t dir_rows[$];

    int  mismatches = 0;
    int  n_insert   = 0;
    int  n_placed   = 0;
    int  n_read     = 0;
    int  n_hit      = 0;
    logic src_calm  = 1'b0;   // stretch with back-to-back items
    int  sink_hold  = 0;

    // Insert: place before the first strictly lower entry, shift the rest down,
    // drop the last. Ties land after existing entries. Read: one ranked entry.
    function automatic outcome_t chart_apply(input req_t q);
        outcome_t o;
        int cell_idx;
        int slot;
        int j;
        logic in_range;
        o = '0;
        in_range = (int'(q.position) < NUM_POS) && (int'(q.tag) < NUM_TAGS);
        cell_idx = int'(q.position) * NUM_TAGS + int'(q.tag);
        if (q.kind == kbci_pkg::KIND_INSERT) begin
            if (in_range) begin
                slot = DEPTH;
                for (j = DEPTH - 1; j >= 0; j--) begin
                    if (chart_score[cell_idx][j] < q.score) slot = j;
                end
                if (slot < DEPTH) begin
                    for (j = DEPTH - 1; j > slot; j--) begin
                        chart_score[cell_idx][j] = chart_score[cell_idx][j-1];
                        chart_feat[cell_idx][j]  = chart_feat[cell_idx][j-1];
                        chart_pred[cell_idx][j]  = chart_pred[cell_idx][j-1];
                    end
                    chart_score[cell_idx][slot] = q.score;
                    chart_feat[cell_idx][slot]  = q.feature;
                    chart_pred[cell_idx][slot]  = q.pred;
                    o.accepted = 1'b1;
                end
            end
        end else if (in_range && int'(q.rank) < DEPTH
                     && chart_score[cell_idx][q.rank] != kbci_pkg::EMPTY_SCORE) begin
            o.entry_valid = 1'b1;
            o.score       = chart_score[cell_idx][q.rank];
            o.feature     = chart_feat[cell_idx][q.rank];
            o.pred        = chart_pred[cell_idx][q.rank];
        end else begin
            o = EMPTY_READ;
        end
        return o;
    endfunction

    function automatic req_t ins_req(input int p, input int t, input logic signed [31:0] s,
                                     input int f, input int r);
        req_t q;
        q = '0;
        q.kind     = kbci_pkg::KIND_INSERT;
        q.position = 7'(p);
        q.tag      = 5'(t);
        q.score    = s;
        q.feature  = 16'(f);
        q.pred     = 16'(r);
        return q;
    endfunction

    function automatic req_t rd_req(input int p, input int t, input int k);
        req_t q;
        q = '0;
        q.kind     = kbci_pkg::KIND_READ;
        q.position = 7'(p);
        q.tag      = 5'(t);
        q.rank     = 3'(k);
        return q;
    endfunction

    function automatic void add_row(input req_t q, input logic typed, input outcome_t want);
        dir_row_t row;
        row.req   = q;
        row.typed = typed;
        row.want  = want;
        dir_rows  = {dir_rows, row};
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        if (src_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Present one item, hold it until the handshake, then log the expected result.
    task automatic push_item(input req_t q, input logic typed, input outcome_t want);
        int gap;
        outcome_t o;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= q.kind;
        s_position    <= q.position;
        s_tag         <= q.tag;
        s_rank        <= q.rank;
        s_score_in    <= q.score;
        s_feature_ref <= q.feature;
        s_pred_ref    <= q.pred;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge
        o = chart_apply(q);
        if (typed) o = want;
        if (q.kind == kbci_pkg::KIND_INSERT) begin
            n_insert++;
            if (o.accepted) n_placed++;
        end else begin
            n_read++;
            if (o.entry_valid) n_hit++;
        end
        pending_outcomes = {pending_outcomes, o};
        if ($urandom_range(0, 79) == 0) src_calm = ~src_calm;
    endtask

    // Result side: check against the oldest expectation, then pick the next
    // m_ready level and how long to hold it (short stalls, a few long ones,
    // and long stretches with no stall at all).
    always @(posedge aclk) begin : sink
        outcome_t w;
        int r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: acc=%0b ev=%0b score=%0d feat=%h pred=%h",
                             m_accepted, m_entry_valid, m_score_out, m_feature_out,
                             m_pred_out);
            end else begin
                w = pending_outcomes.pop_front();
                if (m_accepted !== w.accepted || m_entry_valid !== w.entry_valid
                    || m_score_out !== w.score || m_feature_out !== w.feature
                    || m_pred_out !== w.pred) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected acc=%0b ev=%0b score=%0d feat=%h",
                                  " pred=%h, got acc=%0b ev=%0b score=%0d feat=%h pred=%h"},
                                 w.accepted, w.entry_valid, w.score, w.feature, w.pred,
                                 m_accepted, m_entry_valid, m_score_out, m_feature_out,
                                 m_pred_out);
                end
            end
        end
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_ready   <= 1'b1;
                sink_hold <= $urandom_range(0, 6);
            end else if (r < 92) begin
                m_ready   <= 1'b0;
                sink_hold <= $urandom_range(0, 3);
            end else if (r < 97) begin
                m_ready   <= 1'b0;
                sink_hold <= $urandom_range(10, 40);
            end else begin
                m_ready   <= 1'b1;
                sink_hold <= $urandom_range(50, 150);
            end
        end
    end

    initial begin : stimulus
        int i;
        int n;
        int r;
        int h;
        int sv;
        int hot_pos [HOT_CELLS];
        int hot_tag [HOT_CELLS];
        req_t q;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = kbci_pkg::KIND_INSERT;
        s_position    = '0;
        s_tag         = '0;
        s_rank        = '0;
        s_score_in    = '0;
        s_feature_ref = '0;
        s_pred_ref    = '0;
        m_ready       = 1'b0;
        for (i = 0; i < NUM_POS * NUM_TAGS; i++)
            for (n = 0; n < DEPTH; n++) chart_score[i][n] = kbci_pkg::EMPTY_SCORE;

        // --- directed table ---
        // fresh chart: corner cells read back empty
        add_row(rd_req(0, 0, 0), 1'b1, EMPTY_READ);
        add_row(rd_req(NUM_POS - 1, NUM_TAGS - 1, DEPTH - 1), 1'b1, EMPTY_READ);
        // top score into the last cell, then read it back
        add_row(ins_req(NUM_POS - 1, NUM_TAGS - 1, 32'sh7FFF_FFFF, 16'hFFFF, 0), 1'b1,
                INS_PLACED);
        add_row(rd_req(NUM_POS - 1, NUM_TAGS - 1, 0), 1'b1,
                '{1'b0, 1'b1, 32'sh7FFF_FFFF, 16'hFFFF, 16'h0000});
        // the empty marker itself never finds a strictly lower entry
        add_row(ins_req(NUM_POS - 1, NUM_TAGS - 1, kbci_pkg::EMPTY_SCORE, 1, 1), 1'b1,
                INS_REFUSED);
        // tie at the top goes behind the existing entry
        add_row(ins_req(NUM_POS - 1, NUM_TAGS - 1, 32'sh7FFF_FFFF, 1, kbci_pkg::PRED_NONE),
                1'b0, '0);
        add_row(rd_req(NUM_POS - 1, NUM_TAGS - 1, 1), 1'b0, '0);
        // lowest legal score still beats an empty slot
        add_row(ins_req(0, 0, 32'sh8000_0001, 0, 0), 1'b1, INS_PLACED);
        add_row(rd_req(0, 0, 0), 1'b1, '{1'b0, 1'b1, 32'sh8000_0001, 16'h0000, 16'h0000});
        // fill one list with rising scores, each new one lands on top
        for (i = 1; i <= DEPTH; i++)
            add_row(ins_req(5, 9, 10 * i, i, 100 + i), 1'b0, '0);
        // worst entry higher than the score: refused
        add_row(ins_req(5, 9, 5, 16'hAAAA, 16'h5555), 1'b1, INS_REFUSED);
        // middle insert shifts the tail, lowest drops out; a score below the new worst is refused
        add_row(ins_req(5, 9, 45, 16'h0045, 16'h0145), 1'b0, '0);
        add_row(ins_req(5, 9, 10, 16'h0010, 16'h0110), 1'b0, '0);
        // tie with the worst entry: nothing strictly lower, refused
        add_row(ins_req(5, 9, 20, 16'h0020, 16'h0120), 1'b0, '0);
        add_row(rd_req(5, 9, 0), 1'b0, '0);
        add_row(rd_req(5, 9, 3), 1'b0, '0);
        add_row(rd_req(5, 9, 4), 1'b0, '0);
        add_row(rd_req(5, 9, DEPTH - 1), 1'b0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[k]) push_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

        // --- random part ---
        // Most traffic goes to a few hot cells with scores from a narrow grid,
        // so lists fill, ties happen and entries shift and drop. The hot set
        // moves now and then. The rest spreads over the whole chart.
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 400 == 0) begin
                for (h = 0; h < HOT_CELLS; h++) begin
                    hot_pos[h] = $urandom_range(0, NUM_POS - 1);
                    hot_tag[h] = $urandom_range(0, NUM_TAGS - 1);
                end
            end
            r = $urandom_range(0, 99);
            h = $urandom_range(0, HOT_CELLS - 1);
            q.kind     = kbci_pkg::KIND_INSERT;
            q.position = 7'($urandom_range(0, NUM_POS - 1));
            q.tag      = 5'($urandom_range(0, NUM_TAGS - 1));
            q.rank     = 3'($urandom_range(0, 7));
            q.score    = $urandom;
            q.feature  = 16'($urandom_range(0, 65535));
            q.pred     = 16'($urandom_range(0, 65535));
            if (r < 42 || r >= 95) begin
                q.position = 7'(hot_pos[h]);
                q.tag      = 5'(hot_tag[h]);
                if (r < 42) begin
                    sv      = (int'($urandom_range(0, 23)) - 12) * 256;
                    q.score = sv;
                end else if ($urandom_range(0, 2) == 0) begin
                    q.score = 32'sh7FFF_FFFF;
                end else if ($urandom_range(0, 1) == 0) begin
                    q.score = 32'sh8000_0001;
                end
            end else if (r < 78) begin
                q.kind     = kbci_pkg::KIND_READ;
                q.position = 7'(hot_pos[h]);
                q.tag      = 5'(hot_tag[h]);
            end else if (r >= 88) begin
                q.kind = kbci_pkg::KIND_READ;
            end
            // the empty marker lies outside the insert score range
            if (q.score == kbci_pkg::EMPTY_SCORE) q.score = 32'sh8000_0001;
            push_item(q, 1'b0, '0);
        end

        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d inserts (%0d placed) and %0d reads (%0d returned an entry)",
                 n_insert, n_placed, n_read, n_hit);
        $display("result mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hang guard: clearing pass plus worst-case gaps and stalls, several times over
    initial begin : watchdog
        #(10_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
